### src/vfc_pkg.sv
// Package for the viewport fit calculator: field widths, fit mode codes and
// the sideband struct that travels beside the divider pipeline.
// No dependencies.
package vfc_pkg;

	localparam int WIN_W = 14;
	localparam int DPI_W = 12;
	localparam int EFF_W = 18;
	localparam int VIRT_W = 14;
	localparam int DIV_W = 34;
	localparam int FRAC_W = 16;

	localparam logic [1:0] MODE_LETTERBOX = 2'd0;
	localparam logic [1:0] MODE_STRETCH = 2'd1;
	localparam logic [1:0] MODE_PIXEL = 2'd2;
	localparam logic [1:0] MODE_OVERSCAN = 2'd3;

	localparam logic [3:0] ADDR_VWIDTH = 4'd0;
	localparam logic [3:0] ADDR_VHEIGHT = 4'd4;
	localparam logic [3:0] ADDR_MODE = 4'd8;

	// Item context carried alongside the dividers.
	typedef struct packed {
		logic [EFF_W-1:0] ew;
		logic [EFF_W-1:0] eh;
		logic [VIRT_W-1:0] vw;
		logic [VIRT_W-1:0] vh;
		logic [1:0] mode;
		logic use_y;
	} side_t;

endpackage

### src/vfc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the stages advance only while ce is high.
module vfc_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] num_p [0:NUM_W];
	logic [DEN_W-1:0] den_p [0:NUM_W];
	logic [DEN_W-1:0] rem_p [0:NUM_W];
	logic [NUM_W-1:0] quo_p [0:NUM_W];

	assign num_p[0] = num;
	assign den_p[0] = den;
	assign rem_p[0] = '0;
	assign quo_p[0] = '0;

	// Each stage brings down one numerator bit and tries a subtract.
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic ge;
		assign trial = {rem_p[i], num_p[i][NUM_W-1-i]};
		assign ge = trial >= {1'b0, den_p[i]};
		always_ff @(posedge clk) begin
			if (ce) begin
				num_p[i+1] <= num_p[i];
				den_p[i+1] <= den_p[i];
				rem_p[i+1] <= ge ? DEN_W'(trial - {1'b0, den_p[i]}) : trial[DEN_W-1:0];
				quo_p[i+1] <= {quo_p[i][NUM_W-2:0], ge};
			end
		end
	end

	assign quo = quo_p[NUM_W];

endmodule

### src/viewport_fit_calculator_top.sv
// Viewport fit calculator top level: config registers, input stages, four
// pipelined dividers and the mode selection stages. Depends on vfc_pkg, vfc_div.
//
// One window event enters per clock while the pipeline advances, and its result word
// passes three input stages (zero fixes, DPI products, cross products), 34
// stages of the restoring divider pipeline, and three output stages. The
// whole pipeline advances together and holds while a finished result word
// waits on the master side. Config writes must be made while the pipeline
// is empty.
module viewport_fit_calculator_top #(
	parameter int DEFAULT_VIRT_WIDTH = 1280,
	parameter int DEFAULT_VIRT_HEIGHT = 720
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// win_width[13:0], win_height[27:14], dpi_factor[39:28]
	input  logic [39:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// scale_main[31:0], scale_horiz[63:32], scale_vert[95:64], offset_x[111:96],
	// offset_y[127:112], area_width[143:128], area_height[159:144]
	output logic [159:0] m_axis_tdata
);
	import vfc_pkg::*;

	localparam int LAT = DIV_W;

	logic [VIRT_W-1:0] vwidth_q, vheight_q;
	logic [1:0] mode_q;
	logic ce;

	// Config registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vwidth_q <= '0;
			vheight_q <= '0;
			mode_q <= MODE_LETTERBOX;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_VWIDTH: vwidth_q <= pwdata[VIRT_W-1:0];
				ADDR_VHEIGHT: vheight_q <= pwdata[VIRT_W-1:0];
				ADDR_MODE: mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_VWIDTH: prdata = {18'd0, vwidth_q};
			ADDR_VHEIGHT: prdata = {18'd0, vheight_q};
			ADDR_MODE: prdata = {30'd0, mode_q};
			default: prdata = '0;
		endcase
	end

	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	// Stage 1: substitute defaults for zero sizes and dpi.
	logic v_s1, v_s2, v_s3;
	logic [WIN_W-1:0] ww_s1, wh_s1;
	logic [DPI_W-1:0] dpi_s1;
	logic [VIRT_W-1:0] vw_s1, vh_s1, vw_s2, vh_s2, vw_s3, vh_s3;
	logic [1:0] mode_s1, mode_s2, mode_s3;
	logic [WIN_W-1:0] in_ww, in_wh;
	logic [DPI_W-1:0] in_dpi;

	assign in_ww = s_axis_tdata[13:0];
	assign in_wh = s_axis_tdata[27:14];
	assign in_dpi = s_axis_tdata[39:28];

	always_ff @(posedge clk) begin
		if (ce) begin
			ww_s1 <= (in_ww == '0) ? WIN_W'(1) : in_ww;
			wh_s1 <= (in_wh == '0) ? WIN_W'(1) : in_wh;
			dpi_s1 <= (in_dpi == '0) ? DPI_W'(256) : in_dpi;
			vw_s1 <= (vwidth_q == '0) ? VIRT_W'(DEFAULT_VIRT_WIDTH) : vwidth_q;
			vh_s1 <= (vheight_q == '0) ? VIRT_W'(DEFAULT_VIRT_HEIGHT) : vheight_q;
			mode_s1 <= mode_q;
		end
	end

	// Stage 2: effective sizes.
	logic [EFF_W-1:0] ew_s2, eh_s2, ew_s3, eh_s3;
	logic [WIN_W+DPI_W-1:0] pw, ph;
	assign pw = (WIN_W+DPI_W)'(ww_s1) * (WIN_W+DPI_W)'(dpi_s1);
	assign ph = (WIN_W+DPI_W)'(wh_s1) * (WIN_W+DPI_W)'(dpi_s1);

	always_ff @(posedge clk) begin
		if (ce) begin
			ew_s2 <= pw[WIN_W+DPI_W-1:8];
			eh_s2 <= ph[WIN_W+DPI_W-1:8];
			vw_s2 <= vw_s1;
			vh_s2 <= vh_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: cross products for the aspect test and the scaled sizes.
	localparam int XP_W = EFF_W + VIRT_W;
	logic [XP_W-1:0] ewvh_s3, ehvw_s3;
	always_ff @(posedge clk) begin
		if (ce) begin
			ewvh_s3 <= XP_W'(ew_s2) * XP_W'(vh_s2);
			ehvw_s3 <= XP_W'(eh_s2) * XP_W'(vw_s2);
			ew_s3 <= ew_s2;
			eh_s3 <= eh_s2;
			vw_s3 <= vw_s2;
			vh_s3 <= vh_s2;
			mode_s3 <= mode_s2;
		end
	end

	// Valid bits for the input stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Dividers: both Q16.16 axis scales and both cross-scaled sizes.
	logic wider;
	logic [DIV_W-1:0] qx, qy, cx, cy;
	assign wider = ewvh_s3 > ehvw_s3;

	vfc_div #(.NUM_W(DIV_W), .DEN_W(VIRT_W)) u_div_qx (
		.clk(clk), .ce(ce), .num({ew_s3, 16'd0}), .den(vw_s3), .quo(qx));
	vfc_div #(.NUM_W(DIV_W), .DEN_W(VIRT_W)) u_div_qy (
		.clk(clk), .ce(ce), .num({eh_s3, 16'd0}), .den(vh_s3), .quo(qy));
	vfc_div #(.NUM_W(DIV_W), .DEN_W(VIRT_W)) u_div_cx (
		.clk(clk), .ce(ce), .num(DIV_W'(ewvh_s3)), .den(vw_s3), .quo(cx));
	vfc_div #(.NUM_W(DIV_W), .DEN_W(VIRT_W)) u_div_cy (
		.clk(clk), .ce(ce), .num(DIV_W'(ehvw_s3)), .den(vh_s3), .quo(cy));

	// Context shift line matching the divider latency.
	side_t side_p [0:LAT];
	logic [LAT:0] vld_p;
	assign side_p[0] = '{ew: ew_s3, eh: eh_s3, vw: vw_s3, vh: vh_s3, mode: mode_s3,
		use_y: ((mode_s3 == MODE_LETTERBOX) && wider) ||
			((mode_s3 == MODE_OVERSCAN) && !wider)};
	assign vld_p[0] = v_s3;

	for (genvar i = 0; i < LAT; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (ce) begin
				side_p[i+1] <= side_p[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[i+1] <= 1'b0;
			end else if (ce) begin
				vld_p[i+1] <= vld_p[i];
			end
		end
	end

	side_t sd;
	assign sd = side_p[LAT];

	// Output stage 1: pick the axis and the integer scale.
	logic v_s4, v_s5;
	side_t sd_s4, sd_s5;
	logic [31:0] sx_s4, sy_s4, ssel_s4;
	logic [DIV_W-1:0] aw_s4, ah_s4;
	logic [EFF_W-1:0] k_s4;
	logic [31:0] sx_sat, sy_sat;
	logic [EFF_W-1:0] kx, ky, kmin;

	assign sx_sat = (qx[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : qx[31:0];
	assign sy_sat = (qy[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : qy[31:0];
	assign kx = qx[DIV_W-1:FRAC_W];
	assign ky = qy[DIV_W-1:FRAC_W];
	assign kmin = (kx < ky) ? kx : ky;

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s4 <= sd;
			sx_s4 <= sx_sat;
			sy_s4 <= sy_sat;
			ssel_s4 <= sd.use_y ? sy_sat : sx_sat;
			if (sd.mode == MODE_STRETCH) begin
				aw_s4 <= DIV_W'(sd.ew);
				ah_s4 <= DIV_W'(sd.eh);
			end else begin
				aw_s4 <= sd.use_y ? cy : DIV_W'(sd.ew);
				ah_s4 <= sd.use_y ? DIV_W'(sd.eh) : cx;
			end
			k_s4 <= (kmin == '0) ? EFF_W'(1) : kmin;
		end
	end

	// Output stage 2: final scales and areas per mode.
	logic [31:0] sm_s5, sx_s5, sy_s5, kscale;
	logic [DIV_W-1:0] aw_s5, ah_s5;
	localparam int KA_W = EFF_W + VIRT_W;
	logic [KA_W-1:0] kaw, kah;
	assign kscale = (k_s4[EFF_W-1:FRAC_W] != '0) ? 32'hFFFF_FFFF :
		{k_s4[FRAC_W-1:0], 16'd0};
	assign kaw = KA_W'(sd_s4.vw) * KA_W'(k_s4);
	assign kah = KA_W'(sd_s4.vh) * KA_W'(k_s4);

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s5 <= sd_s4;
			unique case (sd_s4.mode)
				MODE_STRETCH: begin
					sm_s5 <= (sx_s4 < sy_s4) ? sx_s4 : sy_s4;
					sx_s5 <= sx_s4;
					sy_s5 <= sy_s4;
					aw_s5 <= aw_s4;
					ah_s5 <= ah_s4;
				end
				MODE_PIXEL: begin
					sm_s5 <= kscale;
					sx_s5 <= kscale;
					sy_s5 <= kscale;
					aw_s5 <= DIV_W'(kaw);
					ah_s5 <= DIV_W'(kah);
				end
				default: begin
					sm_s5 <= ssel_s4;
					sx_s5 <= ssel_s4;
					sy_s5 <= ssel_s4;
					aw_s5 <= aw_s4;
					ah_s5 <= ah_s4;
				end
			endcase
		end
	end

	// Output stage 3: centering offsets, saturation and the result word.
	function automatic logic [15:0] half_off(input logic [EFF_W-1:0] eff,
			input logic [DIV_W-1:0] sz);
		logic signed [DIV_W+1:0] d;
		logic signed [DIV_W+1:0] h;
		d = $signed({2'b00, DIV_W'(eff)}) - $signed({2'b00, sz});
		h = (d + $signed((DIV_W+2)'(d[DIV_W+1]))) >>> 1;
		if (h > $signed((DIV_W+2)'(32767))) half_off = 16'h7FFF;
		else if (h < -$signed((DIV_W+2)'(32768))) half_off = 16'h8000;
		else half_off = h[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata[31:0] <= sm_s5;
			m_axis_tdata[63:32] <= sx_s5;
			m_axis_tdata[95:64] <= sy_s5;
			m_axis_tdata[111:96] <= half_off(sd_s5.ew, aw_s5);
			m_axis_tdata[127:112] <= half_off(sd_s5.eh, ah_s5);
			m_axis_tdata[143:128] <= (aw_s5[DIV_W-1:16] != '0) ? 16'hFFFF : aw_s5[15:0];
			m_axis_tdata[159:144] <= (ah_s5[DIV_W-1:16] != '0) ? 16'hFFFF : ah_s5[15:0];
		end
	end

	// Valid bits for the output stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			v_s4 <= vld_p[LAT];
			v_s5 <= v_s4;
			m_axis_tvalid <= v_s5;
		end
	end

endmodule

### tb/viewport_fit_calculator_top_tb.sv
// Self-checking testbench for the viewport fit calculator top level.
// It drives window events and APB register writes, predicts each fit result and compares it.
// Depends on vfc_pkg and viewport_fit_calculator_top.
module viewport_fit_calculator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vfc_pkg::*;

	localparam int DEF_VW = 1280;
	localparam int DEF_VH = 720;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [15:0] area_height;
		logic [15:0] area_width;
		logic [15:0] offset_y;
		logic [15:0] offset_x;
		logic [31:0] scale_vert;
		logic [31:0] scale_horiz;
		logic [31:0] scale_main;
	} fit_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [159:0] m_axis_tdata;

	int error_count;
	int in_count;
	int out_count;
	int idle_cycles;
	bit long_stall;

	// Predicts fit results and holds them in order of arrival.
	class fit_scoreboard;
		logic [13:0] vw_reg;
		logic [13:0] vh_reg;
		logic [1:0] mode_reg;
		fit_t pending[$];

		function new();
			vw_reg = '0;
			vh_reg = '0;
			mode_reg = MODE_LETTERBOX;
		endfunction

		function logic [31:0] q_ratio(longint unsigned num, longint unsigned den);
			longint unsigned q;
			q = (num << 16) / den;
			return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		function logic [15:0] half_off(longint unsigned eff, longint unsigned scaled);
			longint d;
			d = (longint'(eff) - longint'(scaled)) / 2;
			if (d > 32767) d = 32767;
			if (d < -32768) d = -32768;
			return d[15:0];
		endfunction

		function logic [15:0] sat16(longint unsigned v);
			return (v > 65535) ? 16'hFFFF : v[15:0];
		endfunction

		function void note_event(logic [39:0] word);
			longint unsigned ww, wh, dpi, vw, vh, ew, eh, sm, sx, sy, aw, ah, k;
			bit wider;
			fit_t r;
			ww = word[13:0];
			wh = word[27:14];
			dpi = word[39:28];
			vw = (vw_reg != 0) ? vw_reg : DEF_VW;
			vh = (vh_reg != 0) ? vh_reg : DEF_VH;
			if (ww == 0) ww = 1;
			if (wh == 0) wh = 1;
			if (dpi == 0) dpi = 256;
			ew = (ww * dpi) >> 8;
			eh = (wh * dpi) >> 8;
			wider = (ew * vh) > (eh * vw);
			case (mode_reg)
				MODE_LETTERBOX, MODE_OVERSCAN: begin
					if (wider == (mode_reg == MODE_LETTERBOX)) begin
						sm = q_ratio(eh, vh);
						aw = (vw * eh) / vh;
						ah = eh;
					end else begin
						sm = q_ratio(ew, vw);
						aw = ew;
						ah = (vh * ew) / vw;
					end
					sx = sm;
					sy = sm;
				end
				MODE_STRETCH: begin
					sx = q_ratio(ew, vw);
					sy = q_ratio(eh, vh);
					sm = (sx < sy) ? sx : sy;
					aw = ew;
					ah = eh;
				end
				default: begin
					k = ((ew / vw) < (eh / vh)) ? ew / vw : eh / vh;
					if (k < 1) k = 1;
					sm = ((k << 16) > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : (k << 16);
					sx = sm;
					sy = sm;
					aw = vw * k;
					ah = vh * k;
				end
			endcase
			r.scale_main = sm[31:0];
			r.scale_horiz = sx[31:0];
			r.scale_vert = sy[31:0];
			r.offset_x = half_off(ew, aw);
			r.offset_y = half_off(eh, ah);
			r.area_width = sat16(aw);
			r.area_height = sat16(ah);
			pending.push_back(r);
		endfunction

		function int check_result(logic [159:0] word, output string why);
			fit_t got, want;
			got = word;
			why = "";
			if (pending.size() == 0) begin
				why = "result word with nothing expected";
				return 1;
			end
			want = pending.pop_front();
			if (got.scale_main !== want.scale_main)
				why = {why, $sformatf(" scale_main %h/%h", got.scale_main, want.scale_main)};
			if (got.scale_horiz !== want.scale_horiz)
				why = {why, $sformatf(" scale_horiz %h/%h", got.scale_horiz, want.scale_horiz)};
			if (got.scale_vert !== want.scale_vert)
				why = {why, $sformatf(" scale_vert %h/%h", got.scale_vert, want.scale_vert)};
			if (got.offset_x !== want.offset_x)
				why = {why, $sformatf(" offset_x %h/%h", got.offset_x, want.offset_x)};
			if (got.offset_y !== want.offset_y)
				why = {why, $sformatf(" offset_y %h/%h", got.offset_y, want.offset_y)};
			if (got.area_width !== want.area_width)
				why = {why, $sformatf(" area_width %h/%h", got.area_width, want.area_width)};
			if (got.area_height !== want.area_height)
				why = {why, $sformatf(" area_height %h/%h", got.area_height, want.area_height)};
			return (why != "");
		endfunction
	endclass

	fit_scoreboard fit_sb;

	viewport_fit_calculator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Writes one register through a setup and an access phase, then returns the bus to idle.
	task automatic apb_write(logic [3:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_VWIDTH: fit_sb.vw_reg = data[13:0];
			ADDR_VHEIGHT: fit_sb.vh_reg = data[13:0];
			default: fit_sb.mode_reg = data[1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_canvas(int vw, int vh, logic [1:0] mode);
		apb_write(ADDR_VWIDTH, vw);
		apb_write(ADDR_VHEIGHT, vh);
		apb_write(ADDR_MODE, mode);
	endtask

	// Offers one word and holds it until accepted.
	task automatic send_event(logic [13:0] ww, logic [13:0] wh, logic [11:0] dpi);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dpi, wh, ww};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		fit_sb.note_event({dpi, wh, ww});
		in_count++;
	endtask

	task automatic pause_sender(int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits for all results, then lets the pipeline settle before a write.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (fit_sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [11:0] rand_dpi();
		case ($urandom_range(0, 5))
			0: return 12'd0;
			1: return 12'd256;
			2: return 12'($urandom_range(0, 16));
			3: return 12'hFFF;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [13:0] rand_win();
		case ($urandom_range(0, 5))
			0: return 14'd0;
			1: return 14'h3FFF;
			2: return 14'($urandom_range(0, 8));
			default: return 14'($urandom_range(0, 16383));
		endcase
	endfunction

	// Receiver: random stall pattern plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_stall) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0) || (in_count % 200 < 40);
		end
	end

	// Result checking and the idle watchdog.
	always @(posedge clk) begin
		string why;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_count++;
				if (fit_sb.check_result(m_axis_tdata, why)) report_mismatch(why);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("** viewport_fit_calculator_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int vw_pick[6];
		fit_sb = new();
		error_count = 0;
		in_count = 0;
		out_count = 0;
		idle_cycles = 0;
		long_stall = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default canvas, each mode, extremes and tiny sizes.
		for (int m = 0; m < 4; m++) begin
			if (m != 0) apb_write(ADDR_MODE, m);
			send_event(14'd1920, 14'd1080, 12'd256);
			send_event(14'd0, 14'd0, 12'd0);
			send_event(14'h3FFF, 14'h3FFF, 12'hFFF);
			send_event(14'd3, 14'd2, 12'd1);
			send_event(14'h3FFF, 14'd1, 12'hFFF);
			send_event(14'd1, 14'h3FFF, 12'd512);
			drain();
		end
		set_canvas(1, 1, MODE_PIXEL);
		send_event(14'h3FFF, 14'h3FFF, 12'hFFF);
		drain();
		apb_write(ADDR_MODE, MODE_STRETCH);
		send_event(14'h3FFF, 14'h2000, 12'hFFF);
		drain();
		set_canvas(14'h3FFF, 14'h3FFF, MODE_LETTERBOX);
		send_event(14'd1, 14'd1, 12'd1);
		drain();

		// Long hold-off on the receiver while the sender keeps offering.
		fork
			begin
				long_stall = 1'b1;
				repeat (300) @(posedge clk);
				long_stall = 1'b0;
			end
			for (int i = 0; i < 60; i++)
				send_event(rand_win(), rand_win(), rand_dpi());
		join
		drain();

		// Random phases over several canvas settings.
		vw_pick = '{0, 1, 8192, 16383, 320, 7};
		for (int p = 0; p < 12; p++) begin
			set_canvas((p < 6) ? vw_pick[p] : $urandom_range(0, 16383),
				(p < 6) ? vw_pick[5 - p] : $urandom_range(0, 16383), 2'(p % 4));
			n = 0;
			while (n < 80) begin
				for (int b = $urandom_range(1, 20); b > 0 && n < 80; b--) begin
					send_event(rand_win(), rand_win(), rand_dpi());
					n++;
				end
				if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
			end
			drain();
		end

		$display("Covered %0d window events and %0d results over all four fit modes,",
			in_count, out_count);
		$display("default, minimum and out-of-range canvases, and a long output stall.");
		if (error_count == 0 && fit_sb.pending.size() == 0) begin
			$display("** viewport_fit_calculator_top: PASSED **");
		end else begin
			$display("** viewport_fit_calculator_top: FAILED **");
		end
		$finish;
	end

endmodule

### viewport_fit_calculator_top.f
src/vfc_pkg.sv
src/vfc_div.sv
src/viewport_fit_calculator_top.sv
tb/viewport_fit_calculator_top_tb.sv
